// ===== rtl/per_class_box_nms_core_assert.svh =====
// Assertion macros for the per-class box NMS core.
// Depends on nothing; included by the top level only.
`ifndef PER_CLASS_BOX_NMS_CORE_ASSERT_SVH
`define PER_CLASS_BOX_NMS_CORE_ASSERT_SVH

// same-cycle implication
`define PCNMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcnms assertion failed");

// next-cycle implication
`define PCNMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcnms assertion failed");

`endif

// ===== rtl/pcnms_pkg.sv =====
// Package for the per-class box NMS core: sizes, register indexes, state codes.
// No dependencies.
`timescale 1ns / 1ps

package pcnms_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    localparam int GEO_W = 64;   // {cx, cy, w, h}
    localparam int TAG_W = 24;   // {score, class}

    localparam int MUL_W  = 18;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 54;

    typedef enum logic [0:0] {
        REG_SCORE_THR = 1'b0,
        REG_OVL_THR   = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SA, ST_SB, ST_SC,
        ST_PA, ST_PB, ST_PC, ST_PD, ST_PE,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
        ST_EA, ST_EB, ST_EC, ST_ED
    } state_t;

endpackage

// ===== rtl/pcnms_if.sv =====
// Channel interfaces of the per-class box NMS core: candidate in, kept box out.
// Depends on nothing.
`timescale 1ns / 1ps

interface pcnms_cand_if;
    logic        valid;
    logic        ready;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] score;
    logic [7:0]  class_label;
    logic        final_box;
    modport source (output valid, center_x, center_y, box_width, box_height, score,
                    class_label, final_box, input ready);
    modport sink   (input valid, center_x, center_y, box_width, box_height, score,
                    class_label, final_box, output ready);
endinterface

interface pcnms_kept_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_center_x;
    logic [15:0] out_center_y;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [15:0] out_score;
    logic [7:0]  out_class;
    logic        last_kept;
    modport source (output valid, out_center_x, out_center_y, out_width, out_height,
                    out_score, out_class, last_kept, input ready);
    modport sink   (input valid, out_center_x, out_center_y, out_width, out_height,
                    out_score, out_class, last_kept, output ready);
endinterface

// ===== rtl/per_class_box_nms_core.sv =====
// Per-class NMS core. Load: one candidate per cycle while ready is high.
// After the final_box transfer: rank sort, then suppression of same-class pairs on
// one shared 18x18 multiplier, then output of the survivors, which may stall on the
// output channel. Next frame loads only after the last transfer.
// Reset (rst_n low, async): thresholds to defaults, store empty, flags clear.
// Depends on pcnms_pkg, pcnms_if.sv and per_class_box_nms_core_assert.svh.
`timescale 1ns / 1ps
`include "per_class_box_nms_core_assert.svh"

module per_class_box_nms_core
    import pcnms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    pcnms_cand_if.sink          cand,
    pcnms_kept_if.source        kept
);

    // configuration
    logic [15:0] score_thr_reg;
    logic [15:0] ovl_thr_reg;

    // storage: geometry and tags by load order, sort result by rank
    logic [GEO_W-1:0] geo_mem [MAX_BOXES];
    logic [TAG_W-1:0] tag_mem [MAX_BOXES];
    logic [IDX_W-1:0] ord_mem [MAX_BOXES];
    logic [GEO_W-1:0] geo_rd_reg;
    logic [TAG_W-1:0] tag_rd_reg;
    logic [IDX_W-1:0] ord_rd_reg;
    logic [IDX_W-1:0] st_raddr;
    logic [IDX_W-1:0] ord_raddr;

    // sequencer
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] i_reg, j_reg, last_reg;
    logic [CNT_W-1:0] rank_reg;
    logic [MAX_BOXES-1:0] supp_reg;
    logic [CNT_W-1:0] n_last;
    logic             i_end, j_end;

    // pair datapath
    logic [TAG_W-1:0] tag_a_reg;
    logic [GEO_W-1:0] geo_a_reg, geo_b_reg;
    logic [7:0]       cls_a_reg;
    logic [MUL_W-1:0] dx_reg, dy_reg;
    logic             disj_reg;
    logic [PROD_W-1:0] inter_reg, union_reg;
    logic [PROD_W-3:0] area_reg;
    logic [ACC_W-1:0]  cmp_reg;
    logic [MUL_W-1:0]  mul_x, mul_y;
    logic [PROD_W-1:0] mul_p;

    // output register
    logic [GEO_W-1:0] o_geo_reg;
    logic [TAG_W-1:0] o_tag_reg;
    logic             o_last_reg;

    logic cand_xfer, kept_xfer, keep_box, ahead;
    logic signed [18:0] la, ra, ta, ba, lb, rb, tb, bb, l_mx, r_mn, t_mx, b_mn;

    assign cand_xfer = cand.valid && cand.ready;
    assign kept_xfer = kept.valid && kept.ready;
    assign keep_box  = (cand.score > score_thr_reg) && (cnt_reg < CNT_W'(MAX_BOXES));
    assign n_last    = cnt_reg - CNT_W'(1);
    assign i_end     = ({1'b0, i_reg} == n_last);
    assign j_end     = ({1'b0, j_reg} == n_last);

    // rank order: class ascending, score descending, load order
    always_comb
    begin
        ahead = (tag_rd_reg[7:0] < tag_a_reg[7:0]) ||
                ((tag_rd_reg[7:0] == tag_a_reg[7:0]) &&
                 ((tag_rd_reg[23:8] > tag_a_reg[23:8]) ||
                  ((tag_rd_reg[23:8] == tag_a_reg[23:8]) && (j_reg < i_reg))));
    end

    // doubled-coordinate edges: 2*centre -/+ size, no rounding
    always_comb
    begin
        la = $signed({2'b0, geo_a_reg[63:48], 1'b0}) - $signed({3'b0, geo_a_reg[31:16]});
        ra = $signed({2'b0, geo_a_reg[63:48], 1'b0}) + $signed({3'b0, geo_a_reg[31:16]});
        ta = $signed({2'b0, geo_a_reg[47:32], 1'b0}) - $signed({3'b0, geo_a_reg[15:0]});
        ba = $signed({2'b0, geo_a_reg[47:32], 1'b0}) + $signed({3'b0, geo_a_reg[15:0]});
        lb = $signed({2'b0, geo_rd_reg[63:48], 1'b0}) - $signed({3'b0, geo_rd_reg[31:16]});
        rb = $signed({2'b0, geo_rd_reg[63:48], 1'b0}) + $signed({3'b0, geo_rd_reg[31:16]});
        tb = $signed({2'b0, geo_rd_reg[47:32], 1'b0}) - $signed({3'b0, geo_rd_reg[15:0]});
        bb = $signed({2'b0, geo_rd_reg[47:32], 1'b0}) + $signed({3'b0, geo_rd_reg[15:0]});
        l_mx = (la > lb) ? la : lb;
        r_mn = (ra < rb) ? ra : rb;
        t_mx = (ta > tb) ? ta : tb;
        b_mn = (ba < bb) ? ba : bb;
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        unique case (state_reg)
            ST_M0:
            begin
                mul_x = dx_reg;
                mul_y = dy_reg;
            end
            ST_M1:
            begin
                mul_x = {2'b0, geo_a_reg[31:16]};
                mul_y = {2'b0, geo_a_reg[15:0]};
            end
            ST_M2:
            begin
                mul_x = {2'b0, geo_b_reg[31:16]};
                mul_y = {2'b0, geo_b_reg[15:0]};
            end
            ST_M4:
            begin
                mul_x = {2'b0, ovl_thr_reg};
                mul_y = union_reg[MUL_W-1:0];
            end
            ST_M5:
            begin
                mul_x = {2'b0, ovl_thr_reg};
                mul_y = union_reg[PROD_W-1:MUL_W];
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end
    assign mul_p = mul_x * mul_y;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: if (cand_xfer && cand.final_box)
                         state_next = (keep_box || cnt_reg != '0) ? ST_SA : ST_LOAD;
            ST_SA:   state_next = ST_SB;
            ST_SB:   state_next = ST_SC;
            ST_SC:   if (j_end) state_next = i_end ? ST_PA : ST_SA;
            ST_PA:   if (supp_reg[i_reg]) state_next = i_end ? ST_EA : ST_PA;
                     else state_next = ST_PB;
            ST_PB:   state_next = ST_PC;
            ST_PC:   state_next = i_end ? ST_EA : ST_PD;
            ST_PD:   state_next = ST_PE;
            ST_PE:
            begin
                if (tag_rd_reg[7:0] != cls_a_reg)
                    state_next = i_end ? ST_EA : ST_PA;
                else if (supp_reg[j_reg])
                    state_next = j_end ? (i_end ? ST_EA : ST_PA) : ST_PD;
                else
                    state_next = ST_M0;
            end
            ST_M0:   if (disj_reg) state_next = j_end ? (i_end ? ST_EA : ST_PA) : ST_PD;
                     else state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_M4;
            ST_M4:   state_next = ST_M5;
            ST_M5:   state_next = ST_M6;
            ST_M6:   state_next = j_end ? (i_end ? ST_EA : ST_PA) : ST_PD;
            ST_EA:   state_next = supp_reg[i_reg] ? ST_EA : ST_EB;
            ST_EB:   state_next = ST_EC;
            ST_EC:   state_next = ST_ED;
            ST_ED:   if (kept_xfer) state_next = o_last_reg ? ST_LOAD : ST_EA;
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs and memory read addresses
    always_comb
    begin
        st_raddr  = i_reg;
        ord_raddr = i_reg;
        unique case (state_reg)
            ST_SB:   st_raddr = '0;
            ST_SC:   st_raddr = j_reg + IDX_W'(1);
            ST_PB,
            ST_PD,
            ST_EB:   st_raddr = ord_rd_reg;
            ST_PC:   ord_raddr = i_reg + IDX_W'(1);
            ST_PE,
            ST_M0,
            ST_M6:   ord_raddr = j_reg + IDX_W'(1);
            default:
            begin
                st_raddr  = i_reg;
                ord_raddr = i_reg;
            end
        endcase
    end

    assign cand.ready        = (state_reg == ST_LOAD);
    assign kept.valid        = (state_reg == ST_ED);
    assign kept.out_center_x = o_geo_reg[63:48];
    assign kept.out_center_y = o_geo_reg[47:32];
    assign kept.out_width    = o_geo_reg[31:16];
    assign kept.out_height   = o_geo_reg[15:0];
    assign kept.out_score    = o_tag_reg[23:8];
    assign kept.out_class    = o_tag_reg[7:0];
    assign kept.last_kept    = o_last_reg;

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cand_xfer && keep_box)
        begin
            geo_mem[cnt_reg[IDX_W-1:0]] <= {cand.center_x, cand.center_y,
                                            cand.box_width, cand.box_height};
            tag_mem[cnt_reg[IDX_W-1:0]] <= {cand.score, cand.class_label};
        end
        if (state_reg == ST_SC && j_end)
            ord_mem[IDX_W'(rank_reg + CNT_W'(ahead))] <= i_reg;
        geo_rd_reg <= geo_mem[st_raddr];
        tag_rd_reg <= tag_mem[st_raddr];
        ord_rd_reg <= ord_mem[ord_raddr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_thr_reg <= 16'd32768;
            ovl_thr_reg   <= 16'd26214;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SCORE_THR: score_thr_reg <= cfg_wdata;
                REG_OVL_THR:   ovl_thr_reg   <= cfg_wdata;
                default:       score_thr_reg <= score_thr_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            supp_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            rank_reg  <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_LOAD:
                begin
                    if (cand_xfer && keep_box)
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    i_reg <= '0;
                end
                ST_SB:
                begin
                    j_reg    <= '0;
                    rank_reg <= '0;
                end
                ST_SC:
                begin
                    rank_reg <= rank_reg + CNT_W'(ahead);
                    j_reg    <= j_reg + IDX_W'(1);
                    if (j_end)
                        i_reg <= i_end ? '0 : i_reg + IDX_W'(1);
                end
                ST_PA:
                begin
                    if (supp_reg[i_reg])
                        i_reg <= i_end ? '0 : i_reg + IDX_W'(1);
                    else
                        last_reg <= i_reg;
                end
                ST_PC:
                begin
                    if (i_end)
                        i_reg <= '0;
                    j_reg <= i_reg + IDX_W'(1);
                end
                ST_PE:
                begin
                    if (tag_rd_reg[7:0] != cls_a_reg)
                        i_reg <= i_end ? '0 : i_reg + IDX_W'(1);
                    else if (supp_reg[j_reg])
                    begin
                        if (j_end)
                            i_reg <= i_end ? '0 : i_reg + IDX_W'(1);
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                ST_M0:
                begin
                    if (disj_reg)
                    begin
                        if (j_end)
                            i_reg <= i_end ? '0 : i_reg + IDX_W'(1);
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                ST_M6:
                begin
                    // inter*65536 > thresh*union, both scaled by 4
                    if ({2'b0, inter_reg, 16'b0} > cmp_reg)
                        supp_reg[j_reg] <= 1'b1;
                    if (j_end)
                        i_reg <= i_end ? '0 : i_reg + IDX_W'(1);
                    j_reg <= j_reg + IDX_W'(1);
                end
                ST_EA:
                begin
                    if (supp_reg[i_reg])
                        i_reg <= i_reg + IDX_W'(1);
                end
                ST_ED:
                begin
                    if (kept_xfer)
                    begin
                        if (o_last_reg)
                        begin
                            cnt_reg  <= '0;
                            supp_reg <= '0;
                            i_reg    <= '0;
                        end
                        else
                            i_reg <= i_reg + IDX_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // pair datapath and output payload, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_SB: tag_a_reg <= tag_rd_reg;
            ST_PC:
            begin
                geo_a_reg <= geo_rd_reg;
                cls_a_reg <= tag_rd_reg[7:0];
            end
            ST_PE:
            begin
                geo_b_reg <= geo_rd_reg;
                disj_reg  <= (l_mx > r_mn) || (t_mx > b_mn);
                dx_reg    <= MUL_W'(r_mn - l_mx);
                dy_reg    <= MUL_W'(b_mn - t_mx);
            end
            ST_M0: inter_reg <= mul_p;
            ST_M1: area_reg  <= mul_p[PROD_W-3:0];
            ST_M2: area_reg  <= area_reg + mul_p[PROD_W-3:0];
            ST_M3: union_reg <= {area_reg, 2'b0} - inter_reg;
            ST_M4: cmp_reg   <= ACC_W'(mul_p);
            ST_M5: cmp_reg   <= cmp_reg + {mul_p, 18'b0};
            ST_EC:
            begin
                o_geo_reg  <= geo_rd_reg;
                o_tag_reg  <= tag_rd_reg;
                o_last_reg <= (i_reg == last_reg);
            end
            default:
            begin
            end
        endcase
    end

    // the store never holds more than its depth
    `PCNMS_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(MAX_BOXES))
    // loading and result delivery never overlap
    `PCNMS_ASSERT_IMP(a_no_overlap, clk, rst_n, kept.valid, !cand.ready)
    // after the last survivor goes out the frame is cleared
    `PCNMS_ASSERT_NXT(a_frame_clr, clk, rst_n, kept_xfer && kept.last_kept,
                      cnt_reg == '0 && supp_reg == '0 && cand.ready)
    // the first ranked box is never suppressed
    `PCNMS_ASSERT_IMP(a_head_kept, clk, rst_n, state_reg == ST_EA, !supp_reg[0])

endmodule

// ===== test/tb_per_class_box_nms_core.sv =====
// Self-checking testbench for per_class_box_nms_core: directed and random frames of candidates.
// It predicts the kept boxes of each frame and compares every output transfer field by field.
// Depends on pcnms_pkg, rtl/pcnms_if.sv and the core itself.
`timescale 1ns / 1ps

module tb_per_class_box_nms_core;
    import pcnms_pkg::*;

    // One candidate box as loaded into the store.
    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] sc;
        logic [7:0]  cls;
    } box_t;

    // One kept-box transfer on the output channel.
    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] sc;
        logic [7:0]  cls;
        logic        last;
    } kept_t;

    // Directed table row; n_kept is the typed frame result count, -1 where the
    // predictor alone decides.
    typedef struct {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] sc;
        logic [7:0]  cls;
        logic        fin;
        int          n_kept;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_wdata;

    pcnms_cand_if cand ();
    pcnms_kept_if kept ();

    per_class_box_nms_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cand      (cand.sink),
        .kept      (kept.source)
    );

    // Predictor state: thresholds and the boxes loaded so far in this frame.
    logic [15:0] score_thr;
    logic [15:0] iou_thr;
    box_t        frame_boxes[$];
    kept_t       kept_expected[$];
    int          errors;
    int          last_frame_n;   // boxes in the most recent frame, sizes the idle wait

    // Sender burst bookkeeping.
    int          burst_left;

    // Receiver stall pattern.
    int          stall_mode = 0;
    int          stall_cnt = 0;
    int          stall_hold = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // class ascending, then score descending, then load order
    function automatic bit ranks_ahead(int a, int b);
        if (frame_boxes[a].cls != frame_boxes[b].cls)
            return frame_boxes[a].cls < frame_boxes[b].cls;
        if (frame_boxes[a].sc != frame_boxes[b].sc)
            return frame_boxes[a].sc > frame_boxes[b].sc;
        return a < b;
    endfunction

    // IoU test without division. Edges in doubled coordinates, so both intersection
    // and union carry a factor of four, which cancels out of the comparison.
    function automatic bit iou_exceeds(int a, int b);
        longint l, r, t, bt, inter4, union4;
        longint pw, ph, qw, qh;
        box_t p, q;
        p  = frame_boxes[a];
        q  = frame_boxes[b];
        pw = longint'(p.w);
        ph = longint'(p.h);
        qw = longint'(q.w);
        qh = longint'(q.h);
        l  = (2 * longint'(p.cx) - pw > 2 * longint'(q.cx) - qw) ?
             2 * longint'(p.cx) - pw : 2 * longint'(q.cx) - qw;
        r  = (2 * longint'(p.cx) + pw < 2 * longint'(q.cx) + qw) ?
             2 * longint'(p.cx) + pw : 2 * longint'(q.cx) + qw;
        t  = (2 * longint'(p.cy) - ph > 2 * longint'(q.cy) - qh) ?
             2 * longint'(p.cy) - ph : 2 * longint'(q.cy) - qh;
        bt = (2 * longint'(p.cy) + ph < 2 * longint'(q.cy) + qh) ?
             2 * longint'(p.cy) + ph : 2 * longint'(q.cy) + qh;
        if (l > r || t > bt)
            return 1'b0;
        inter4 = (r - l) * (bt - t);
        union4 = 4 * (pw * ph) + 4 * (qw * qh) - inter4;
        return inter4 * 65536 > longint'(iou_thr) * union4;
    endfunction

    // Sort, suppress within each class run, queue the survivors. Returns their count.
    function automatic int close_frame();
        int    ord[MAX_BOXES];
        bit    supp[MAX_BOXES];
        int    n, key, j, cnt;
        kept_t k;
        n   = frame_boxes.size();
        cnt = 0;
        for (int i = 0; i < n; i++)
        begin
            key = i;
            j   = i;
            while (j > 0 && ranks_ahead(key, ord[j - 1]))
            begin
                ord[j] = ord[j - 1];
                j--;
            end
            ord[j]  = key;
            supp[i] = 1'b0;
        end
        for (int i = 0; i < n; i++)
        begin
            if (!supp[i])
            begin
                for (int m = i + 1; m < n; m++)
                begin
                    if (frame_boxes[ord[m]].cls != frame_boxes[ord[i]].cls)
                        break;
                    if (!supp[m] && iou_exceeds(ord[i], ord[m]))
                        supp[m] = 1'b1;
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (!supp[i])
            begin
                k = {frame_boxes[ord[i]], 1'b0};
                kept_expected = {kept_expected, k};
                cnt++;
            end
        end
        if (cnt > 0)
            kept_expected[kept_expected.size() - 1].last = 1'b1;
        last_frame_n = n;
        frame_boxes.delete();
        return cnt;
    endfunction

    // Model one accepted candidate; returns the result count on a closing transfer.
    function automatic int load_candidate(box_t b, logic fin);
        if (b.sc > score_thr && frame_boxes.size() < MAX_BOXES)
            frame_boxes = {frame_boxes, b};
        if (fin)
            return close_frame();
        return 0;
    endfunction

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------

    // Present one candidate and hold it until the transfer; then maybe start a gap.
    task automatic send_candidate(box_t b, logic fin, int n_kept);
        int got;
        cand.valid       <= 1'b1;
        cand.center_x    <= b.cx;
        cand.center_y    <= b.cy;
        cand.box_width   <= b.w;
        cand.box_height  <= b.h;
        cand.score       <= b.sc;
        cand.class_label <= b.cls;
        cand.final_box   <= fin;
        do
            @(posedge clk);
        while (!cand.ready);
        got = load_candidate(b, fin);
        if (n_kept >= 0 && got != n_kept)
        begin
            $display("%0t: frame result count expected %0d actual prediction %0d",
                     $time, n_kept, got);
            errors++;
        end
        // bursts of random length, random gaps between them
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 3) != 0)
            begin
                cand.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // Wait until every expected transfer has come, then for the back end to settle:
    // an empty frame gives no transfer to wait on, so allow for its whole sort and sweep.
    task automatic drain_and_settle();
        cand.valid <= 1'b0;
        while (kept_expected.size() != 0)
            @(posedge clk);
        repeat (11 * last_frame_n * last_frame_n + 6 * last_frame_n + 50) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_SCORE_THR)
            score_thr = val;
        else
            iou_thr = val;
    endtask

    // Random frame. Most boxes sit in a small field with few classes so that
    // overlaps and suppression are common; some use every bit of every field.
    task automatic random_frame(int n);
        box_t b;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                b.cx  = $urandom_range(0, 65535);
                b.cy  = $urandom_range(0, 65535);
                b.w   = $urandom_range(0, 65535);
                b.h   = $urandom_range(0, 65535);
                b.cls = $urandom_range(0, 255);
            end
            else
            begin
                b.cx  = $urandom_range(400, 1600);
                b.cy  = $urandom_range(400, 1600);
                b.w   = $urandom_range(0, 800);
                b.h   = $urandom_range(0, 800);
                b.cls = $urandom_range(0, 3);
            end
            b.sc = $urandom_range(0, 65535);
            send_candidate(b, i == n - 1, -1);
        end
    endtask

    task automatic random_frames(int items);
        int n;
        while (items > 0)
        begin
            n = $urandom_range(1, 12);
            if (n > items)
                n = items;
            random_frame(n);
            items -= n;
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: stall pattern and checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        kept_t act, want;
        if (kept.valid && kept.ready)
        begin
            act = {kept.out_center_x, kept.out_center_y, kept.out_width, kept.out_height,
                   kept.out_score, kept.out_class, kept.last_kept};
            if (kept_expected.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none actual %h", $time, act);
                errors++;
            end
            else
            begin
                want = kept_expected.pop_front();
                if (act !== want)
                begin
                    $display("%0t: kept box mismatch", $time);
                    $display("  cx exp %h act %h  cy exp %h act %h", want.cx, act.cx,
                             want.cy, act.cy);
                    $display("  w exp %h act %h  h exp %h act %h", want.w, act.w,
                             want.h, act.h);
                    $display("  score exp %h act %h  class exp %h act %h  last exp %b act %b",
                             want.sc, act.sc, want.cls, act.cls, want.last, act.last);
                    errors++;
                end
            end
        end
        // stall mode is drawn anew at regular intervals: always ready, coin flip, long stalls
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 96 == 0)
            stall_mode <= $urandom_range(0, 2);
        if (stall_mode == 0)
            kept.ready <= 1'b1;
        else if (stall_mode == 1)
            kept.ready <= $urandom_range(0, 1);
        else if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
            kept.ready <= 1'b0;
        end
        else
        begin
            stall_hold <= ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : 0;
            kept.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    dir_row_t dir_rows[16];

    initial
    begin
        box_t b;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_SCORE_THR;
        cfg_wdata        = '0;
        cand.valid       = 1'b0;
        cand.center_x    = '0;
        cand.center_y    = '0;
        cand.box_width   = '0;
        cand.box_height  = '0;
        cand.score       = '0;
        cand.class_label = '0;
        cand.final_box   = 1'b0;
        score_thr        = 16'd32768;
        iou_thr          = 16'd26214;
        errors           = 0;
        last_frame_n     = 0;
        burst_left       = 0;

        // Default thresholds throughout this table.
        dir_rows = '{
            // largest values everywhere, lone box
            '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,  1},
            // score equal to threshold: dropped, empty frame
            '{16'd0,    16'd0,    16'd0,    16'd0,    16'h8000, 8'd0,  1'b1,  0},
            '{16'd100,  16'd100,  16'd50,   16'd50,   16'd0,    8'd0,  1'b1,  0},
            // identical boxes, same class: lower score suppressed
            '{16'd800,  16'd800,  16'd160,  16'd160,  16'd40000, 8'd3, 1'b0, -1},
            '{16'd800,  16'd800,  16'd160,  16'd160,  16'd50000, 8'd3, 1'b1,  1},
            // identical boxes, different classes: both kept, class order
            '{16'd800,  16'd800,  16'd160,  16'd160,  16'd40000, 8'd2, 1'b0, -1},
            '{16'd800,  16'd800,  16'd160,  16'd160,  16'd50000, 8'd1, 1'b1,  2},
            // zero-area boxes: zero union, nothing suppressed
            '{16'd800,  16'd800,  16'd0,    16'd0,    16'd40000, 8'd5, 1'b0, -1},
            '{16'd800,  16'd800,  16'd0,    16'd0,    16'd50000, 8'd5, 1'b1,  2},
            // disjoint boxes
            '{16'd100,  16'd100,  16'd32,   16'd32,   16'd60000, 8'd7, 1'b0, -1},
            '{16'd4000, 16'd4000, 16'd32,   16'd32,   16'd60000, 8'd7, 1'b1,  2},
            // equal scores, far apart: load order kept
            '{16'd100,  16'd100,  16'd16,   16'd16,   16'd45000, 8'd9, 1'b0, -1},
            '{16'd2000, 16'd2000, 16'd16,   16'd16,   16'd45000, 8'd9, 1'b0, -1},
            '{16'd4000, 16'd4000, 16'd16,   16'd16,   16'd45000, 8'd9, 1'b1,  3},
            // partial overlap near the limit
            '{16'd800,  16'd800,  16'd160,  16'd160,  16'd50000, 8'd0, 1'b0, -1},
            '{16'd880,  16'd800,  16'd160,  16'd160,  16'd49000, 8'd0, 1'b1, -1}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            b = '{dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].w, dir_rows[i].h,
                  dir_rows[i].sc, dir_rows[i].cls};
            send_candidate(b, dir_rows[i].fin, dir_rows[i].n_kept);
        end

        // Lowest thresholds: every nonzero score loads, any overlap suppresses. The long
        // frame overfills the store, the rest of it is dropped.
        drain_and_settle();
        write_reg(REG_SCORE_THR, 16'd0);
        write_reg(REG_OVL_THR, 16'd0);
        random_frame(70);
        random_frames(40);

        // Highest thresholds: nothing passes, every frame is empty.
        drain_and_settle();
        write_reg(REG_SCORE_THR, 16'hFFFF);
        write_reg(REG_OVL_THR, 16'hFFFF);
        random_frames(30);

        drain_and_settle();
        write_reg(REG_SCORE_THR, 16'd20000);
        write_reg(REG_OVL_THR, 16'd30000);
        random_frames(80);

        drain_and_settle();
        write_reg(REG_SCORE_THR, 16'd40000);
        write_reg(REG_OVL_THR, 16'd16384);
        random_frames(80);

        cand.valid <= 1'b0;
        while (kept_expected.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("[per_class_box_nms_core] OK");
        else
            $display("[per_class_box_nms_core] ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #20ms;
        $display("[per_class_box_nms_core] ERROR");
        $finish;
    end

endmodule
